// File: src/assert_macros.svh
// Assertion macros shared by the stencil sweep RTL.
// Included by every module that checks its own control logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define JSS_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("stencil sweep: property violated");

// Next-cycle implication, disabled during reset.
`define JSS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("stencil sweep: property violated");

`endif

// File: src/jss_pkg.sv
// Shared types, sizes and helpers of the Jacobi stencil sweep.
// Used by the front end, queue, back end and top level; depends on nothing.
package jss_pkg;

  localparam int MAX_ROWS    = 1024;
  localparam int MAX_COLS    = 1024;
  localparam int STORE_DEPTH = MAX_COLS + 2;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int ROW_W       = $clog2(MAX_ROWS + 2);
  localparam int SIZE_W      = 11;
  localparam int DATA_W      = 16;
  localparam int SUM_W       = 19;
  localparam int RECIP_SHIFT = 21;
  localparam int RECIP_K     = (2 ** RECIP_SHIFT + 4) / 5;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int APB_ADDR_W  = 3;
  localparam int APB_DATA_W  = 32;

  typedef enum logic {
    KIND_CELL   = 1'b0,
    KIND_REPORT = 1'b1
  } kind_t;

  typedef enum logic {
    REG_ROWS = 1'b0,
    REG_COLS = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic [SIZE_W-1:0] rows;
    logic [SIZE_W-1:0] cols;
  } size_cfg_t;

  typedef struct packed {
    logic [DATA_W-1:0] sample;
    logic [DATA_W-1:0] up;
    logic [DATA_W-1:0] left;
    logic [DATA_W-1:0] right;
    logic [DATA_W-1:0] centre;
    logic              active;
    logic              last;
  } stencil_t;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] hi);
    logic [SIZE_W-1:0] res;
    res = v;
    if (v == '0) begin
      res = SIZE_W'(1);
    end else if (v > hi) begin
      res = hi;
    end
    return res;
  endfunction

endpackage

// File: src/jss_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; used for the line stores of the stencil front end.
module jss_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1026
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/jss_front.sv
// Front end: raster position tracking, line stores and 5-point window.
// Depends on jss_pkg, jss_ram and assert_macros.svh; feeds jss_queue.
`include "assert_macros.svh"

module jss_front (
  input  logic                     clk,
  input  logic                     rst,
  input  jss_pkg::size_cfg_t       size_cfg,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [jss_pkg::DATA_W-1:0] in_sample,
  input  logic                     in_last,
  input  logic                     q_full,
  output logic                     q_push,
  output jss_pkg::stencil_t        q_data
);
  import jss_pkg::*;

  localparam int CMP_W = ((ADDR_W > SIZE_W) ? ADDR_W : SIZE_W) + 1;

  logic [ADDR_W-1:0]   col;
  logic [ADDR_W-1:0]   col_next_pos;
  logic [ADDR_W-1:0]   col_next;
  logic [ADDR_W-1:0]   rd_addr_b;
  logic [ROW_W-1:0]    row;
  logic [ROW_W-1:0]    row_next_pos;
  logic [DATA_W-1:0]   left;
  logic [DATA_W-1:0]   up;
  logic [DATA_W-1:0]   centre;
  logic [DATA_W-1:0]   right;
  logic [2*DATA_W-1:0] rd_pair;
  logic [2*DATA_W-1:0] wr_pair;
  logic [2*DATA_W-1:0] byp_pair;
  logic [DATA_W-1:0]   rd_mid_b;
  logic [DATA_W-1:0]   byp_mid;
  logic                byp_a;
  logic                byp_b;
  logic                accept;
  logic                active;
  logic [SIZE_W-1:0]   rows_c;
  logic [SIZE_W-1:0]   cols_c;

  assign rows_c   = clamp_size(size_cfg.rows, SIZE_W'(MAX_ROWS));
  assign cols_c   = clamp_size(size_cfg.cols, SIZE_W'(MAX_COLS));
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Forward the entry written in the previous cycle when the read hit it.
  assign centre = byp_a ? byp_pair[DATA_W-1:0] : rd_pair[DATA_W-1:0];
  assign up     = byp_a ? byp_pair[2*DATA_W-1:DATA_W] : rd_pair[2*DATA_W-1:DATA_W];
  assign right  = (col == ADDR_W'(STORE_DEPTH - 1)) ? '0 : (byp_b ? byp_mid : rd_mid_b);

  assign active = (CMP_W'(row) >= CMP_W'(2)) && (col != '0) &&
                  (CMP_W'(col) <= CMP_W'(cols_c));

  always_comb begin
    priority if (in_last) begin
      col_next_pos = '0;
      row_next_pos = '0;
    end else if (CMP_W'(col) >= CMP_W'(cols_c) + CMP_W'(1)) begin
      col_next_pos = '0;
      row_next_pos = (CMP_W'(row) >= CMP_W'(rows_c) + CMP_W'(1)) ? '0 : row + ROW_W'(1);
    end else begin
      col_next_pos = col + ADDR_W'(1);
      row_next_pos = row;
    end
  end

  assign col_next  = accept ? col_next_pos : col;
  assign rd_addr_b = (col_next == ADDR_W'(STORE_DEPTH - 1)) ? '0 : col_next + ADDR_W'(1);
  assign wr_pair   = {centre, in_sample};

  // Upper and middle rows side by side, read at the current column.
  jss_ram #(
    .WIDTH (2 * DATA_W),
    .DEPTH (STORE_DEPTH)
  ) u_ram_pair (
    .clk   (clk),
    .we    (accept),
    .waddr (col),
    .wdata (wr_pair),
    .raddr (col_next),
    .rdata (rd_pair)
  );

  // Copy of the middle row, read one column ahead for the right neighbor.
  jss_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STORE_DEPTH)
  ) u_ram_right (
    .clk   (clk),
    .we    (accept),
    .waddr (col),
    .wdata (in_sample),
    .raddr (rd_addr_b),
    .rdata (rd_mid_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      col   <= '0;
      row   <= '0;
      left  <= '0;
      byp_a <= 1'b0;
      byp_b <= 1'b0;
    end else begin
      byp_a <= accept && (col_next == col);
      byp_b <= accept && (rd_addr_b == col);
      if (accept) begin
        col      <= col_next_pos;
        row      <= row_next_pos;
        left     <= centre;
        byp_pair <= wr_pair;
        byp_mid  <= in_sample;
      end
    end
  end

  // Drop border positions that produce no result.
  assign q_push        = accept && (active || in_last);
  assign q_data.sample = in_sample;
  assign q_data.up     = up;
  assign q_data.left   = left;
  assign q_data.right  = right;
  assign q_data.centre = centre;
  assign q_data.active = active;
  assign q_data.last   = in_last;

  `JSS_ASSERT_NEXT(a_last_rewinds, clk, rst, accept && in_last, col == '0 && row == '0)

endmodule

// File: src/jss_queue.sv
// Four-entry queue of stencil windows between front and back end.
// Depends on jss_pkg and assert_macros.svh.
`include "assert_macros.svh"

module jss_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  jss_pkg::stencil_t push_data,
  output logic              full,
  input  logic              pop,
  output logic              pop_valid,
  output jss_pkg::stencil_t pop_data
);
  import jss_pkg::*;

  stencil_t          entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full      = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign pop_valid = (count != '0);
  assign pop_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        entries[wr_ptr] <= push_data;
        wr_ptr          <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + (QPTR_W + 1)'(1);
        2'b01:   count <= count - (QPTR_W + 1)'(1);
        default: count <= count;
      endcase
    end
  end

  `JSS_ASSERT_IMPL(a_no_push_when_full, clk, rst, full, !push)
  `JSS_ASSERT_IMPL(a_no_pop_when_empty, clk, rst, !pop_valid, !pop)

endmodule

// File: src/jss_back.sv
// Back end: five-point sum, divide by five, change tracking and output register.
// Depends on jss_pkg and assert_macros.svh; pops jss_queue.
`include "assert_macros.svh"

module jss_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_valid,
  input  jss_pkg::stencil_t          q_data,
  output logic                       q_pop,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [jss_pkg::DATA_W-1:0] m_tdata,
  output jss_pkg::kind_t             m_tuser,
  output logic                       m_tlast
);
  import jss_pkg::*;

  logic                  adv;
  logic [SUM_W-1:0]      sum;
  logic                  s1_valid;
  logic [SUM_W-1:0]      s1_sum;
  logic [DATA_W-1:0]     s1_centre;
  logic                  s1_active;
  logic                  s1_last;
  logic [SUM_W-1:0]      dividend;
  logic [SUM_W-1:0]      recip;
  logic [2*SUM_W-1:0]    prod;
  logic                  s2_valid;
  logic [DATA_W-1:0]     s2_value;
  logic [DATA_W-1:0]     s2_centre;
  logic                  s2_active;
  logic                  s2_last;
  logic [DATA_W-1:0]     diff;
  logic [DATA_W-1:0]     cand;
  logic [DATA_W-1:0]     mx;
  logic [DATA_W-1:0]     largest;

  // The whole pipe moves when the output register is free or being drained.
  assign adv   = !m_tvalid || m_tready;
  assign q_pop = adv && q_valid;

  assign sum = SUM_W'(q_data.up) + SUM_W'(q_data.sample) + SUM_W'(q_data.left) +
               SUM_W'(q_data.right) + SUM_W'(q_data.centre);

  // Round to nearest: (sum + 2) / 5 through a reciprocal, exact for this range.
  assign dividend = s1_sum + SUM_W'(2);
  assign recip    = SUM_W'(RECIP_K);
  assign prod     = dividend * recip;

  assign diff = (s2_value >= s2_centre) ? s2_value - s2_centre : s2_centre - s2_value;
  assign cand = s2_active ? diff : '0;
  assign mx   = (cand > largest) ? cand : largest;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      m_tvalid <= 1'b0;
      largest  <= '0;
    end else if (adv) begin
      s1_valid  <= q_valid;
      s1_sum    <= sum;
      s1_centre <= q_data.centre;
      s1_active <= q_data.active;
      s1_last   <= q_data.last;

      s2_valid  <= s1_valid;
      s2_value  <= prod[RECIP_SHIFT+DATA_W-1:RECIP_SHIFT];
      s2_centre <= s1_centre;
      s2_active <= s1_active;
      s2_last   <= s1_last;

      m_tvalid <= s2_valid;
      if (s2_valid) begin
        if (s2_last) begin
          m_tdata <= mx;
          m_tuser <= KIND_REPORT;
          m_tlast <= 1'b1;
          largest <= '0;
        end else begin
          m_tdata <= s2_value;
          m_tuser <= KIND_CELL;
          m_tlast <= 1'b0;
          largest <= mx;
        end
      end
    end
  end

  `JSS_ASSERT_NEXT(a_report_clears_max, clk, rst, adv && s2_valid && s2_last, largest == '0)

endmodule

// File: src/jacobi_stencil_sweep.sv
// Top level of the Jacobi 5-point stencil sweep: register port and block wiring.
// Depends on jss_pkg, jss_front, jss_queue and jss_back.
//
// Usage:
//   s_* stream: padded tile in raster order, (rows + 2) x (cols + 2) samples,
//   unsigned Q1.15 in s_tdata, s_tlast high on the final sample of the tile.
//   m_* stream: one result per interior cell, the rounded mean of the cell
//   and its four neighbors (m_tuser = 0), and on the tile's last sample one report
//   of the largest absolute change (m_tuser = 1, m_tlast = 1) instead of that cell.
//   APB port: interior_rows at 0x0, interior_cols at 0x4, 11 bits each,
//   clamped to 1..1024; write them between tiles.
// Timing:
//   One sample per cycle sustained while the queue is not full; the line stores
//   are read and written once per sample, one column ahead for the right neighbor.
//   A result reaches m_* through a queue entry, the sum stage, the
//   reciprocal-multiply stage and the output register.
// Reset: positions, running maximum, queue and pipeline are cleared; the line
//   stores are not cleared, and rows of a tile fill them before use.
// Stall: while m_tready is low the back end holds; the four-entry queue takes
//   further samples and then s_tready drops until the receiver drains it.
module jacobi_stencil_sweep (
  input  logic                           clk,
  input  logic                           rst,
  // sample [15:0]
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [jss_pkg::DATA_W-1:0]     s_tdata,
  input  logic                           s_tlast,
  // value [15:0]
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [jss_pkg::DATA_W-1:0]     m_tdata,
  // kind [0]
  output logic                           m_tuser,
  output logic                           m_tlast,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [jss_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [jss_pkg::APB_DATA_W-1:0] pwdata,
  output logic [jss_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);
  import jss_pkg::*;

  size_cfg_t  size_cfg;
  reg_index_t reg_index;
  logic       q_full;
  logic       q_push;
  stencil_t   q_in;
  logic       q_pop;
  logic       q_valid;
  stencil_t   q_out;
  kind_t      out_kind;

  assign pready    = 1'b1;
  assign reg_index = reg_index_t'(paddr[APB_ADDR_W-1]);

  always_ff @(posedge clk) begin
    if (rst) begin
      size_cfg.rows <= SIZE_W'(16);
      size_cfg.cols <= SIZE_W'(16);
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_index)
        REG_ROWS: size_cfg.rows <= pwdata[SIZE_W-1:0];
        REG_COLS: size_cfg.cols <= pwdata[SIZE_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_ROWS: prdata = APB_DATA_W'(size_cfg.rows);
      REG_COLS: prdata = APB_DATA_W'(size_cfg.cols);
    endcase
  end

  jss_front u_front (
    .clk       (clk),
    .rst       (rst),
    .size_cfg  (size_cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_sample (s_tdata),
    .in_last   (s_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_in)
  );

  jss_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (q_out)
  );

  jss_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_data   (q_out),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (out_kind),
    .m_tlast  (m_tlast)
  );

  assign m_tuser = out_kind;

endmodule

// File: bench/tb.sv
// Self-checking bench for the Jacobi 5-point stencil sweep: streams padded tiles,
// predicts every cell update and change report, and compares them in order.
// Depends on jss_pkg and jacobi_stencil_sweep.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import jss_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES   = 300;
  localparam int MODE_ITEMS    = 300;

  typedef enum int {FILL_RANDOM, FILL_FULL_SCALE, FILL_CHECKER} fill_t;
  typedef enum int {END_ON_LAST, END_WRAP, END_EARLY} tile_end_t;

  typedef struct packed {
    logic [DATA_W-1:0] cell_value;
    logic              last;
  } tile_sample_t;

  typedef struct packed {
    kind_t             kind;
    logic [DATA_W-1:0] value;
    logic              end_of_sweep;
  } sweep_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [DATA_W-1:0]     s_tdata = '0;    // sample [15:0]
  logic                  s_tlast = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [DATA_W-1:0]     m_tdata;         // value [15:0]
  logic                  m_tuser;         // kind [0]
  logic                  m_tlast;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  jacobi_stencil_sweep dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always #10 clk = ~clk;

  // Stimulus and traffic shaping
  tile_sample_t  tile_samples[$];
  sweep_result_t predicted_results[$];
  tile_sample_t  next_sample;
  int            queued_count = 0;
  int            accepted_count = 0;
  int            error_count = 0;
  int            send_idle_pct = 0;
  int            recv_idle_pct = 0;
  int            hold_requests = 0;
  int            holds_served = 0;
  int            hold_left = 0;
  int            cycle_count = 0;

  // Stencil state as the block should hold it
  logic [SIZE_W-1:0] cfg_rows = SIZE_W'(16);
  logic [SIZE_W-1:0] cfg_cols = SIZE_W'(16);
  logic [DATA_W-1:0] upper_row [STORE_DEPTH] = '{default: '0};
  logic [DATA_W-1:0] middle_row[STORE_DEPTH] = '{default: '0};
  logic [DATA_W-1:0] prev_centre = '0;
  int unsigned       row_pos = 0;
  int unsigned       col_pos = 0;
  logic [DATA_W-1:0] max_change = '0;

  function automatic int unsigned dim_clamp(input logic [SIZE_W-1:0] v, input int unsigned hi);
    if (v == '0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void apply_stencil(input logic [DATA_W-1:0] s, input logic last);
    int unsigned   rows, cols, c, r, sum, nv, diff;
    logic [DATA_W-1:0] left, centre, right, up;
    sweep_result_t res;
    rows = dim_clamp(cfg_rows, MAX_ROWS);
    cols = dim_clamp(cfg_cols, MAX_COLS);
    c = col_pos;
    r = row_pos;
    if (c >= STORE_DEPTH) c = STORE_DEPTH - 1;
    left   = prev_centre;
    centre = middle_row[c];
    right  = (c + 1 < STORE_DEPTH) ? middle_row[c + 1] : '0;
    up     = upper_row[c];
    if (r >= 2 && c >= 1 && c <= cols) begin
      sum  = up + s + left + right + centre;
      nv   = (sum + 2) / 5;
      diff = (nv >= centre) ? nv - centre : centre - nv;
      if (diff > max_change) max_change = diff[DATA_W-1:0];
      // a cell that coincides with last is folded into the report only
      if (!last) begin
        res.kind = KIND_CELL;
        res.value = nv[DATA_W-1:0];
        res.end_of_sweep = 1'b0;
        predicted_results.push_back(res);
      end
    end
    upper_row[c]  = centre;
    middle_row[c] = s;
    prev_centre   = centre;
    if (c >= cols + 1) begin
      col_pos = 0;
      row_pos = (r >= rows + 1) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
    if (last) begin
      res.kind = KIND_REPORT;
      res.value = max_change;
      res.end_of_sweep = 1'b1;
      predicted_results.push_back(res);
      max_change = '0;
      row_pos = 0;
      col_pos = 0;
    end
  endfunction

  // Sender: hold the offered sample until it is taken, then maybe idle
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (tile_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_sample = tile_samples.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= next_sample.cell_value;
        s_tlast  <= next_sample.last;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (holds_served != hold_requests) begin
      holds_served <= holds_served + 1;
      hold_left <= HOLD_CYCLES;
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Predict on every input transfer, check every output transfer
  always @(posedge clk) begin
    sweep_result_t want;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        apply_stencil(s_tdata, s_tlast);
        accepted_count++;
      end
      if (m_tvalid && m_tready) begin
        if (predicted_results.size() == 0) begin
          $display("%0t: unexpected result: got kind %0d value %h last %0b", $time,
                   m_tuser, m_tdata, m_tlast);
          error_count++;
        end else begin
          want = predicted_results.pop_front();
          if (m_tuser !== want.kind) begin
            $display("%0t: kind mismatch: expected %0d, got %0d", $time, want.kind, m_tuser);
            error_count++;
          end
          if (m_tdata !== want.value) begin
            $display("%0t: value mismatch: expected %h, got %h", $time, want.value, m_tdata);
            error_count++;
          end
          if (m_tlast !== want.end_of_sweep) begin
            $display("%0t: end_of_sweep mismatch: expected %0b, got %0b", $time,
                     want.end_of_sweep, m_tlast);
            error_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic write_reg(input reg_index_t idx, input logic [SIZE_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= APB_DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_ROWS) cfg_rows = value;
    else cfg_cols = value;
  endtask

  function automatic logic [DATA_W-1:0] random_sample();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 5) return '0;
    if (pick < 10) return 16'h8000;
    if (pick < 15) return 16'hFFFF;
    if (pick < 25) return DATA_W'($urandom_range(16'hFFFF));
    return DATA_W'($urandom_range(16'h8000));
  endfunction

  // Queue one padded tile at the current sizes, or only its first part for an early end
  task automatic queue_tile(input tile_end_t how, input fill_t fill, input int early_at = -1);
    int total, n, last_idx;
    tile_sample_t ts;
    total = (dim_clamp(cfg_rows, MAX_ROWS) + 2) * (dim_clamp(cfg_cols, MAX_COLS) + 2);
    n = total;
    last_idx = -1;
    case (how)
      END_ON_LAST: last_idx = total - 1;
      END_EARLY: begin
        last_idx = (early_at >= 0) ? early_at : $urandom_range(total - 2, 0);
        n = last_idx + 1;
      end
      default: last_idx = -1;
    endcase
    for (int i = 0; i < n; i++) begin
      case (fill)
        FILL_FULL_SCALE: ts.cell_value = 16'hFFFF;
        FILL_CHECKER:    ts.cell_value = (i % 2 == 0) ? 16'h0000 : 16'h8000;
        default:         ts.cell_value = random_sample();
      endcase
      ts.last = (i == last_idx);
      tile_samples.push_back(ts);
    end
    queued_count += n;
  endtask

  // Wait until every sample is taken and every result is back, then let the pipe empty
  task automatic settle();
    while (accepted_count != queued_count || predicted_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [SIZE_W-1:0] pick_dim(input int unsigned small_hi);
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 8) return '0;
    if (pick < 88) return SIZE_W'($urandom_range(small_hi, 1));
    return SIZE_W'($urandom_range(16, small_hi + 1));
  endfunction

  function automatic tile_end_t pick_end();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 70) return END_ON_LAST;
    if (pick < 85) return END_WRAP;
    return END_EARLY;
  endfunction

  initial begin
    int mode_start;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: zero sizes clamp to a 3x3 padded tile
    send_idle_pct = 35;
    recv_idle_pct = 87;
    write_reg(REG_ROWS, '0);
    write_reg(REG_COLS, '0);
    queue_tile(END_ON_LAST, FILL_FULL_SCALE);
    // last lands on the only interior cell: report replaces it
    queue_tile(END_EARLY, FILL_CHECKER, 7);
    // no last: positions wrap, maximum carries over
    queue_tile(END_WRAP, FILL_CHECKER);
    queue_tile(END_EARLY, FILL_RANDOM, 3);
    settle();

    for (int mode = 0; mode < 3; mode++) begin
      send_idle_pct = (mode == 0) ? 35 : (mode == 1) ? 87 : 0;
      recv_idle_pct = (mode == 0) ? 87 : (mode == 1) ? 35 : 0;
      if (mode == 2) begin
        // stall the output long enough for the input side to back up
        write_reg(REG_ROWS, SIZE_W'(4));
        write_reg(REG_COLS, SIZE_W'(8));
        hold_requests++;
        queue_tile(END_ON_LAST, FILL_RANDOM);
        queue_tile(END_ON_LAST, FILL_RANDOM);
        settle();
      end
      mode_start = queued_count;
      while (queued_count - mode_start < MODE_ITEMS) begin
        write_reg(REG_ROWS, pick_dim(6));
        write_reg(REG_COLS, pick_dim(8));
        repeat ($urandom_range(4, 1)) queue_tile(pick_end(), FILL_RANDOM);
        settle();
      end
    end

    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
